// ===== rtl/nau_pkg.sv =====
`default_nettype none

package nau_pkg;

  // vector store geometry
  localparam int VECTOR_DEPTH = 64;
  localparam int ADDR_W       = $clog2(VECTOR_DEPTH);
  localparam int CNT_W        = $clog2(VECTOR_DEPTH + 1);

  // exp table geometry
  localparam int EXP_TABLE_SIZE = 256;
  localparam int EXP_IDX_W      = $clog2(EXP_TABLE_SIZE);

  // field and register widths
  localparam int DATA_W     = 16;
  localparam int MODE_W     = 3;
  localparam int SLOPE_W    = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = 22;

  // exp datapath widths
  localparam int E_W     = 17;
  localparam int OPND_W  = 17;
  localparam int PROD_W  = 32;
  localparam int T_W     = 26;
  localparam int FRAC_W  = 16;
  localparam int IP_W    = T_W - FRAC_W;
  localparam int SH_W    = 5;
  localparam int LK_W    = DATA_W + SLOPE_W + 1;

  // divider widths
  localparam int Q_W       = 9;
  localparam int NUM_W     = 36;
  localparam int DEN_W     = 35;
  localparam int DS_W      = DEN_W + Q_W - 1;
  localparam int DIV_CNT_W = $clog2(Q_W);

  // fixed-point constants
  localparam logic signed [DATA_W-1:0] ONE_Q8    = 16'sd256;
  localparam logic signed [DATA_W-1:0] DATA_MIN  = 16'sh8000;
  localparam logic [SLOPE_W-1:0]       SLOPE_RST = 16'd655;
  localparam logic signed [15:0]       LOG2E_Q14 = 16'sd23637;
  localparam logic [63:0]              LN2_Q30   = 64'd744261118;
  localparam int                       T_SHIFT   = 6;
  localparam int                       SIG_DEN_SH = 24;
  localparam int                       SIG_NUM_SH = 32;
  localparam logic signed [IP_W-1:0]   IP_SAT_HI = IP_W'(-10);
  localparam logic signed [IP_W-1:0]   IP_SAT_LO = IP_W'(9);

  // activation modes
  typedef enum logic [MODE_W-1:0] {
    MODE_RELU     = 3'd0,
    MODE_DRELU    = 3'd1,
    MODE_LEAKY    = 3'd2,
    MODE_DLEAKY   = 3'd3,
    MODE_SIGMOID  = 3'd4,
    MODE_DSIGMOID = 3'd5,
    MODE_SOFTMAX  = 3'd6,
    MODE_DSOFTMAX = 3'd7
  } mode_t;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOPE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic rd;
    logic mul;
    logic exp;
    logic acc;
    logic load;
    logic div;
    logic wr;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  idx_last;
    logic  sat;
    logic  div_last;
    logic  out_free;
  } status_t;

  // 2^(k/size) in unsigned Q2.15, built at elaboration with a 13-term series
  typedef logic [E_W-1:0] exp_tab_t [EXP_TABLE_SIZE];

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] acc;
    for (int k = 0; k < EXP_TABLE_SIZE; k++) begin
      y    = (64'(k) * LN2_Q30) / EXP_TABLE_SIZE;
      term = 64'd1 << 30;
      acc  = term;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * y) >> 30) / 64'(n);
        acc  = acc + term;
      end
      tab[k] = E_W'((acc + (64'd1 << 14)) >> 15);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ===== rtl/nau_ctrl.sv =====
`default_nettype none

module nau_ctrl
  import nau_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  input  wire logic    s_tlast,
  input  wire status_t st,
  output logic         s_tready,
  output cmd_t         cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_EXP  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_LOAD = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_WR   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   emit_pass, emit_pass_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_pass <= 1'b0;
    end else begin
      state     <= state_next;
      emit_pass <= emit_pass_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    emit_pass_next = emit_pass;
    cmd            = '0;
    s_tready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (st.mode == MODE_SOFTMAX) begin
            if (s_tlast) begin
              emit_pass_next = 1'b0;
              state_next     = S_RD;
            end
          end else if (st.mode == MODE_SIGMOID || st.mode == MODE_DSIGMOID) begin
            state_next = S_MUL;
          end else begin
            state_next = S_WR;
          end
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.exp = 1'b1;
        if (st.mode == MODE_SOFTMAX && !emit_pass) begin
          state_next = S_ACC;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (st.idx_last) begin
          emit_pass_next = 1'b1;
        end
        state_next = S_RD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = st.sat ? S_WR : S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (st.div_last) begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        if (st.out_free) begin
          cmd.wr = 1'b1;
          if (st.mode == MODE_SOFTMAX && !st.idx_last) begin
            state_next = S_RD;
          end else begin
            emit_pass_next = 1'b0;
            state_next     = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // divider is only entered from its operand load
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> ($past(state) == S_LOAD || $past(state) == S_DIV))
    else $error("divider started without operand load");

  // a delivered result leads back to idle or to the next element
  a_wr_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR && st.out_free) |=> (state == S_IDLE || state == S_RD))
    else $error("bad state after result write");
`endif

endmodule

`default_nettype wire

// ===== rtl/nau_dp.sv =====
`default_nettype none

module nau_dp
  import nau_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output status_t                    st,
  input  wire logic [DATA_W-1:0]     s_tdata,
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [DATA_W-1:0]          m_tdata,
  output logic                       m_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration and softmax state
  mode_t                     mode;
  logic [SLOPE_W-1:0]        slope;
  logic [CNT_W-1:0]          count;
  logic signed [DATA_W-1:0]  vmax;
  logic [SUM_W-1:0]          sum;
  logic [ADDR_W-1:0]         idx;

  // vector store
  logic [DATA_W-1:0]         mem [VECTOR_DEPTH];
  logic signed [DATA_W-1:0]  rd_data;
  logic                      mem_we;

  // payload pipeline
  logic signed [OPND_W-1:0]  opnd;
  logic signed [PROD_W-1:0]  prod;
  logic [E_W-1:0]            e_tab;
  logic signed [IP_W-1:0]    ip;
  logic [NUM_W-1:0]          num;
  logic [DS_W-1:0]           ds;
  logic [Q_W-1:0]            q;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic signed [DATA_W-1:0]  res;
  logic                      last_q;

  // output slot
  logic                      out_valid;
  logic [DATA_W-1:0]         out_value;
  logic                      out_last;

  // combinational helpers
  logic signed [DATA_W-1:0]  x;
  logic signed [LK_W-1:0]    lk_full;
  logic [SLOPE_W:0]          dl_sum;
  logic signed [DATA_W-1:0]  simple;
  logic signed [OPND_W-1:0]  mul_in;
  logic signed [T_W-1:0]     t;
  logic [IP_W-1:0]           neg_sh;
  logic [E_W-1:0]            e_sm;
  logic [IP_W-1:0]           ip_p9;
  logic [DEN_W-1:0]          den_sig;
  logic [DEN_W-1:0]          den;
  logic                      sat_hi;
  logic                      sat_lo;
  logic                      is_smax;
  logic                      ge;
  logic [Q_W:0]              q_c;
  logic [2*Q_W:0]            dsig_full;
  logic [DATA_W-1:0]         value_sel;
  logic                      idx_last;

  assign x       = $signed(s_tdata);
  assign is_smax = (mode == MODE_SOFTMAX);
  assign mem_we  = cmd.accept && is_smax && (count < CNT_W'(VECTOR_DEPTH));
  assign idx_last = (CNT_W'(idx) + CNT_W'(1)) == count;

  // elementwise results that need no exp
  assign lk_full = LK_W'(x) * $signed(LK_W'(slope));
  assign dl_sum  = (SLOPE_W + 1)'(slope) + (SLOPE_W + 1)'(128);

  always_comb begin
    case (mode)
      MODE_RELU:   simple = x[DATA_W-1] ? '0 : x;
      MODE_DRELU:  simple = x[DATA_W-1] ? '0 : ONE_Q8;
      MODE_LEAKY:  simple = x[DATA_W-1] ? DATA_W'(lk_full >>> SLOPE_W) : x;
      MODE_DLEAKY: simple = x[DATA_W-1] ? DATA_W'(dl_sum >> 8) : ONE_Q8;
      default:     simple = ONE_Q8;
    endcase
  end

  // exponent argument: x - max for softmax, -x for sigmoid
  assign mul_in = is_smax ? (OPND_W'(rd_data) - OPND_W'(vmax)) : opnd;
  assign t      = T_W'(prod >>> T_SHIFT);

  // softmax exponential: table entry shifted by the integer part
  assign neg_sh = -ip;
  always_comb begin
    if (!ip[IP_W-1]) begin
      e_sm = e_tab;
    end else if (neg_sh >= IP_W'(E_W)) begin
      e_sm = '0;
    end else begin
      e_sm = e_tab >> neg_sh[SH_W-1:0];
    end
  end

  // sigmoid denominator 1 + 2^t in Q.24
  assign ip_p9   = ip + IP_SAT_LO;
  assign den_sig = (DEN_W'(1) << SIG_DEN_SH) + (DEN_W'(e_tab) << ip_p9[SH_W-1:0]);
  assign den     = is_smax ? DEN_W'(sum) : den_sig;
  assign sat_hi  = ip <= IP_SAT_HI;
  assign sat_lo  = ip >= IP_SAT_LO;

  // restoring divider trial
  assign ge = DS_W'(num) >= ds;

  // sigmoid derivative and result select
  assign q_c       = (Q_W + 1)'(256) - (Q_W + 1)'(q);
  assign dsig_full = ((2 * Q_W + 1)'(q) * (2 * Q_W + 1)'(q_c)) + (2 * Q_W + 1)'(128);

  always_comb begin
    case (mode)
      MODE_SIGMOID:  value_sel = DATA_W'(q);
      MODE_DSIGMOID: value_sel = DATA_W'(dsig_full >> 8);
      MODE_SOFTMAX:  value_sel = DATA_W'(q);
      default:       value_sel = res;
    endcase
  end

  // configuration and softmax control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_RELU;
      slope <= SLOPE_RST;
      count <= '0;
      vmax  <= DATA_MIN;
      sum   <= '0;
      idx   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_MODE:  mode  <= mode_t'(cfg_wdata[MODE_W-1:0]);
          CFG_SLOPE: slope <= cfg_wdata[SLOPE_W-1:0];
        endcase
      end
      if (mem_we) begin
        count <= count + CNT_W'(1);
        if (x > vmax) begin
          vmax <= x;
        end
      end
      if (cmd.accept && is_smax && s_tlast) begin
        idx <= '0;
        sum <= '0;
      end
      if (cmd.acc) begin
        sum <= sum + SUM_W'(e_sm);
        idx <= idx_last ? '0 : idx + ADDR_W'(1);
      end
      if (cmd.wr && is_smax) begin
        if (idx_last) begin
          count <= '0;
          vmax  <= DATA_MIN;
          sum   <= '0;
          idx   <= '0;
        end else begin
          idx <= idx + ADDR_W'(1);
        end
      end
    end
  end

  // vector store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[ADDR_W-1:0]] <= s_tdata;
    end
    if (cmd.rd) begin
      rd_data <= $signed(mem[idx]);
    end
  end

  // exp, divider and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      opnd   <= -OPND_W'(x);
      res    <= simple;
      last_q <= s_tlast;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(mul_in) * PROD_W'(LOG2E_Q14);
    end
    if (cmd.exp) begin
      e_tab <= EXP_TAB[t[FRAC_W-1 -: EXP_IDX_W]];
      ip    <= t[T_W-1:FRAC_W];
    end
    if (cmd.load) begin
      if (is_smax) begin
        num <= NUM_W'({e_sm, 8'b0}) + NUM_W'(sum >> 1);
        q   <= '0;
      end else begin
        num <= (NUM_W'(1) << SIG_NUM_SH) + NUM_W'(den_sig >> 1);
        q   <= sat_hi ? Q_W'(256) : '0;
      end
      ds      <= DS_W'(den) << (Q_W - 1);
      div_cnt <= DIV_CNT_W'(Q_W - 1);
    end
    if (cmd.div) begin
      if (ge) begin
        num <= num - NUM_W'(ds);
      end
      q       <= {q[Q_W-2:0], ge};
      ds      <= ds >> 1;
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.wr) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      out_value <= value_sel;
      out_last  <= is_smax ? idx_last : last_q;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tlast  = out_last;

  // status to controller
  assign st.mode     = mode;
  assign st.idx_last = idx_last;
  assign st.sat      = is_smax ? (sum == '0) : (sat_hi || sat_lo);
  assign st.div_last = (div_cnt == '0);
  assign st.out_free = !out_valid || m_tready;

`ifndef SYNTHESIS
  // fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(VECTOR_DEPTH))
    else $error("vector fill count overflow");

  // normalized results stay within one
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr && (mode == MODE_SIGMOID || mode == MODE_SOFTMAX)) |-> q <= Q_W'(256))
    else $error("quotient above one");

  // softmax sum always includes the maximum term
  a_sum_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && is_smax) |-> sum != '0)
    else $error("softmax sum is zero");
`endif

endmodule

`default_nettype wire

// ===== rtl/neural_activation_unit.sv =====
`default_nettype none

// Activation unit for signed Q8.8 samples. The mode register picks relu, its
// derivative, leaky relu, its derivative, sigmoid, its derivative, softmax or
// the softmax derivative (all ones). Elementwise modes give one result per
// input transaction, with tlast copied through; in sigmoid and its derivative
// the divider is skipped when the sigmoid saturates to 0 or 1. In softmax
// mode samples are stored (up to 64, extras dropped) and the vector max
// tracked; the transaction with tlast starts emission of the whole vector,
// first a pass over the stored samples for the exponent sum, then a pass for
// the results. Sigmoid and softmax latency is set by the shared 9-step
// restoring divider and the one-element-per-pass read of the vector store.
// An output register holds the finished result, so the next input is taken
// while it waits. Configuration index 0 is mode, index 1 is the leaky slope
// (unsigned Q0.16). The user must write them through cfg_we/cfg_addr/cfg_wdata
// only while the unit is idle; the unit itself does not enforce this.
module neural_activation_unit
  import nau_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [DATA_W-1:0]     s_tdata,   // [15:0] sample
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [DATA_W-1:0]          m_tdata,   // [15:0] value
  output logic                       m_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t st;

  // sequencer
  nau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .st       (st),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  // store, exp unit, divider and output slot
  nau_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire
